// ===== design/sbsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsa_pkg: shared types and constants of the slab slot allocator
// Field widths, operation and status codes, register indexes, FSM states.
// ----------------------------------------------------------------------------
package sbsa_pkg;

  // Port field widths
  localparam int FUNC_W      = 2;
  localparam int OFFS_W      = 9;   // word_offset
  localparam int STATUS_W    = 2;
  localparam int IDX_OUT_W   = 9;   // slot_index
  localparam int SLOT_OFS_W  = 17;  // slot_offset
  localparam int CNT_W       = 10;  // slot_count, free_count
  localparam int SIZE_W      = 8;
  localparam int HDR_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_POINTERS = 2'd3;

  // Effective configuration, already clamped
  typedef struct packed {
    logic [CNT_W-1:0]  slot_count;
    logic [SIZE_W-1:0] slot_size;
    logic [HDR_W-1:0]  header;
    logic              has_pointers;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [IDX_OUT_W-1:0]  slot_index;
    logic [SLOT_OFS_W-1:0] slot_offset;
    logic                  scan_needed;
    logic                  became_full;
    logic [CNT_W-1:0]      free_count;
  } result_t;

  typedef enum logic [3:0] {
    ST_INIT,    // post-reset fill of the bitmap with ones
    ST_IDLE,
    ST_PREP,    // words in use and padding from slot count
    ST_ASTART,
    ST_SCAN,
    ST_MDIV,
    ST_MWORD,
    ST_MRMW,
    ST_CLR,
    ST_OFFS,
    ST_DONE
  } state_t;

endpackage

// ===== design/sbsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsa_ram: bitmap word memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbsa_ram #(
  parameter int DEPTH = 8,
  parameter int DW    = 64,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sbsa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsa_div: restoring divider, word offset by slot size
// One quotient bit per cycle; done stays high until the next start.
// ----------------------------------------------------------------------------
module sbsa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sbsa_pkg::OFFS_W-1:0] dividend,
  input  logic [sbsa_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [sbsa_pkg::OFFS_W-1:0] quot
);
  import sbsa_pkg::*;

  localparam int STEP_W = $clog2(OFFS_W + 1);

  logic [OFFS_W-1:0] quo_r, quo_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SIZE_W:0]   rem_sh;
  logic [SIZE_W:0]   rem_sub;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[OFFS_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(OFFS_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      // remainder stays below divisor, so it fits SIZE_W bits
      rem_nxt  = ge ? rem_sub[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
      quo_nxt  = {quo_r[OFFS_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== design/sbsa_cdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsa_cdiv: divide by the bitmap word width
// Reciprocal multiply, then one correction step; done pulses.
// ----------------------------------------------------------------------------
module sbsa_cdiv #(
  parameter int WORD_BITS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sbsa_pkg::CNT_W-1:0] value,
  output logic                       done,
  output logic [sbsa_pkg::CNT_W-1:0] quot,
  output logic [((WORD_BITS > 1) ? $clog2(WORD_BITS) : 1)-1:0] rem
);
  import sbsa_pkg::*;

  localparam int BIT_W   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int WB_W    = $clog2(WORD_BITS + 1);
  localparam int SHIFT   = 16;
  localparam int RECIP   = (1 << SHIFT) / WORD_BITS;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = CNT_W + RECIP_W;
  localparam int BACK_W  = CNT_W + WB_W;

  logic [PROD_W-1:0] prod_r;
  logic [CNT_W-1:0]  val_r;
  logic              v1_r;
  logic              done_r;
  logic [CNT_W-1:0]  quot_r;
  logic [BIT_W-1:0]  rem_r;

  logic [CNT_W-1:0]  q_est;
  logic [BACK_W-1:0] back;
  logic [CNT_W-1:0]  r_wide;
  logic              ge;

  // estimate is exact or one low since value < 2^SHIFT
  always_comb begin
    q_est  = CNT_W'(prod_r >> SHIFT);
    back   = BACK_W'(q_est) * BACK_W'(WORD_BITS);
    r_wide = CNT_W'(BACK_W'(val_r) - back);
    ge     = r_wide >= CNT_W'(WORD_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PROD_W'(value) * PROD_W'(RECIP);
      val_r  <= value;
    end
    if (v1_r) begin
      quot_r <= ge ? q_est + 1'b1 : q_est;
      rem_r  <= ge ? BIT_W'(r_wide - CNT_W'(WORD_BITS)) : BIT_W'(r_wide);
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// ===== design/sbsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsa_ctrl: request sequencer
// Runs alloc scan, mark read-modify-write and clear sweep on the bitmap RAM;
// holds free count, search word and the result register.
// ----------------------------------------------------------------------------
module sbsa_ctrl #(
  parameter int MAX_SLOTS = 512,
  parameter int WORD_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sbsa_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sbsa_pkg::FUNC_W-1:0] in_func,
  input  logic [sbsa_pkg::OFFS_W-1:0] in_word_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sbsa_pkg::result_t           out_res,
  output logic                        ram_we,
  output logic [((((MAX_SLOTS + WORD_BITS - 1) / WORD_BITS) > 1) ?
                 $clog2((MAX_SLOTS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] ram_waddr,
  output logic [WORD_BITS-1:0]        ram_wdata,
  output logic [((((MAX_SLOTS + WORD_BITS - 1) / WORD_BITS) > 1) ?
                 $clog2((MAX_SLOTS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] ram_raddr,
  input  logic [WORD_BITS-1:0]        ram_rdata
);
  import sbsa_pkg::*;

  localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int NW_W      = $clog2(NUM_WORDS + 1);
  localparam int BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int PROD_W    = CNT_W + SIZE_W + 1;
  localparam logic [WORD_BITS-1:0] FULL = '1;

  // ones below the excess position
  function automatic logic [WORD_BITS-1:0] low_mask(input logic [BIT_W-1:0] ex);
    logic [WORD_BITS-1:0] m;
    m = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      m[j] = BIT_W'(j) < ex;
    end
    return m;
  endfunction

  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (v[j]) begin
        pos = BIT_W'(j);
      end
    end
    return pos;
  endfunction

  state_t               state_r, state_nxt;
  logic [FUNC_W-1:0]    func_r, func_nxt;
  logic                 below_r, below_nxt;
  logic [NW_W-1:0]      n_r, n_nxt;
  logic [BIT_W-1:0]     excess_r, excess_nxt;
  logic [AW-1:0]        w_r, w_nxt;
  logic [NW_W-1:0]      scanned_r, scanned_nxt;
  logic [AW-1:0]        sweep_r, sweep_nxt;
  logic [AW-1:0]        search_r, search_nxt;
  logic [CNT_W-1:0]     free_r, free_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [BIT_W-1:0]     mbit_r, mbit_nxt;
  logic [STATUS_W-1:0]  rstat_r, rstat_nxt;
  logic [SLOT_OFS_W-1:0] roffs_r, roffs_nxt;
  logic                 rscan_r, rscan_nxt;
  logic                 rfull_r, rfull_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_res_r, out_res_nxt;

  logic                 cdiv_start;
  logic [CNT_W-1:0]     cdiv_val;
  logic                 cdiv_done;
  logic [CNT_W-1:0]     cdiv_quot;
  logic [BIT_W-1:0]     cdiv_rem;
  logic                 div_start;
  logic                 div_done;
  logic [OFFS_W-1:0]    div_quot;
  logic [OFFS_W-1:0]    div_dividend;

  logic [WORD_BITS-1:0] last_mask;
  logic [WORD_BITS-1:0] cur_mask;
  logic [WORD_BITS-1:0] avail;
  logic [BIT_W-1:0]     hit_bit;
  logic [WORD_BITS-1:0] mark_bit;
  logic [NW_W-1:0]      w_inc;
  logic [NW_W-1:0]      sweep_inc;
  logic [AW-1:0]        scan_start;
  logic [PROD_W-1:0]    offs_sum;
  logic                 in_below;

  sbsa_cdiv #(.WORD_BITS(WORD_BITS)) u_cdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cdiv_start),
    .value (cdiv_val),
    .done  (cdiv_done),
    .quot  (cdiv_quot),
    .rem   (cdiv_rem)
  );

  sbsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cfg.slot_size),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    in_below     = in_word_offset < {1'b0, cfg.header};
    div_dividend = in_word_offset - {1'b0, cfg.header};
    last_mask    = (excess_r == '0) ? FULL : low_mask(excess_r);
    w_inc        = NW_W'(w_r) + 1'b1;
    sweep_inc    = NW_W'(sweep_r) + 1'b1;
    cur_mask     = (w_inc < n_r) ? FULL : last_mask;
    avail        = ~ram_rdata & cur_mask;
    hit_bit      = first_set(avail);
    mark_bit     = WORD_BITS'(1) << mbit_r;
    scan_start   = (NW_W'(search_r) < n_r) ? search_r : '0;
    offs_sum     = PROD_W'(idx_r) * PROD_W'(cfg.slot_size) + PROD_W'(cfg.header);

    state_nxt     = state_r;
    func_nxt      = func_r;
    below_nxt     = below_r;
    n_nxt         = n_r;
    excess_nxt    = excess_r;
    w_nxt         = w_r;
    scanned_nxt   = scanned_r;
    sweep_nxt     = sweep_r;
    search_nxt    = search_r;
    free_nxt      = free_r;
    idx_nxt       = idx_r;
    mbit_nxt      = mbit_r;
    rstat_nxt     = rstat_r;
    roffs_nxt     = roffs_r;
    rscan_nxt     = rscan_r;
    rfull_nxt     = rfull_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_res_nxt   = out_res_r;
    in_stall      = state_r != ST_IDLE;
    ram_we        = 1'b0;
    ram_waddr     = w_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = w_r;
    cdiv_start    = 1'b0;
    cdiv_val      = cfg.slot_count;
    div_start     = 1'b0;

    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = FULL;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(NUM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          below_nxt  = in_below;
          idx_nxt    = '0;
          rstat_nxt  = STAT_OK;
          roffs_nxt  = '0;
          rscan_nxt  = 1'b0;
          rfull_nxt  = 1'b0;
          cdiv_start = 1'b1;
          div_start  = (in_func == FUNC_MARK) && !in_below;
          state_nxt  = ST_PREP;
        end
      end
      ST_PREP: begin
        if (cdiv_done) begin
          n_nxt      = NW_W'(cdiv_quot) + NW_W'(cdiv_rem != '0);
          excess_nxt = cdiv_rem;
          case (func_r)
            FUNC_ALLOC: state_nxt = ST_ASTART;
            FUNC_MARK: begin
              if (below_r) begin
                rstat_nxt = STAT_RANGE;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_MDIV;
              end
            end
            FUNC_CLEAR: begin
              sweep_nxt = '0;
              state_nxt = ST_CLR;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ASTART: begin
        if (free_r == '0) begin
          rstat_nxt = STAT_FULL;
          state_nxt = ST_DONE;
        end else begin
          w_nxt       = scan_start;
          ram_raddr   = scan_start;
          scanned_nxt = NW_W'(1);
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (avail != '0) begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata | (WORD_BITS'(1) << hit_bit);
          search_nxt = w_r;
          idx_nxt    = CNT_W'(CNT_W'(w_r) * CNT_W'(WORD_BITS) + CNT_W'(hit_bit));
          free_nxt   = free_r - 1'b1;
          rfull_nxt  = free_r == CNT_W'(1);
          state_nxt  = ST_OFFS;
        end else if (scanned_r == n_r) begin
          rstat_nxt = STAT_FULL;
          state_nxt = ST_DONE;
        end else begin
          w_nxt       = (w_inc < n_r) ? AW'(w_inc) : '0;
          ram_raddr   = w_nxt;
          scanned_nxt = scanned_r + 1'b1;
        end
      end
      ST_MDIV: begin
        if (div_done) begin
          if (CNT_W'(div_quot) >= cfg.slot_count) begin
            rstat_nxt = STAT_RANGE;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt    = CNT_W'(div_quot);
            cdiv_start = 1'b1;
            cdiv_val   = CNT_W'(div_quot);
            state_nxt  = ST_MWORD;
          end
        end
      end
      ST_MWORD: begin
        if (cdiv_done) begin
          w_nxt     = cdiv_quot[AW-1:0];
          mbit_nxt  = cdiv_rem;
          ram_raddr = cdiv_quot[AW-1:0];
          state_nxt = ST_MRMW;
        end
      end
      ST_MRMW: begin
        if ((ram_rdata & mark_bit) == '0) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | mark_bit;
          free_nxt  = (free_r != '0) ? free_r - 1'b1 : '0;
          rscan_nxt = cfg.has_pointers;
          rfull_nxt = free_r <= CNT_W'(1);
        end
        state_nxt = ST_OFFS;
      end
      ST_CLR: begin
        // words below the last are free, the last keeps its padding set,
        // words past the slot count read as used
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        if (sweep_inc < n_r) begin
          ram_wdata = '0;
        end else if (sweep_inc == n_r) begin
          ram_wdata = ~last_mask;
        end else begin
          ram_wdata = FULL;
        end
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(NUM_WORDS - 1)) begin
          free_nxt  = cfg.slot_count;
          state_nxt = ST_DONE;
        end
      end
      ST_OFFS: begin
        roffs_nxt = SLOT_OFS_W'(offs_sum);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_res_nxt.status      = rstat_r;
          out_res_nxt.slot_index  = IDX_OUT_W'(idx_r);
          out_res_nxt.slot_offset = roffs_r;
          out_res_nxt.scan_needed = rscan_r;
          out_res_nxt.became_full = rfull_r;
          out_res_nxt.free_count  = free_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      free_r      <= '0;
      search_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      free_r      <= free_nxt;
      search_r    <= search_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    below_r   <= below_nxt;
    n_r       <= n_nxt;
    excess_r  <= excess_nxt;
    w_r       <= w_nxt;
    scanned_r <= scanned_nxt;
    idx_r     <= idx_nxt;
    mbit_r    <= mbit_nxt;
    rstat_r   <= rstat_nxt;
    roffs_r   <= roffs_nxt;
    rscan_r   <= rscan_nxt;
    rfull_r   <= rfull_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== design/slab_bitmap_slot_allocator.sv =====
`timescale 1ns / 1ps
// Operation: alloc scans bitmap words (1..8 at defaults), one RAM read
//   per cycle; mark runs the 9-step offset/size divider; clear
//   writes all NUM_WORDS words, one RAM word written per cycle.
// Throughput: one request at a time; the next is taken as soon as the result is registered.
// Reset: synchronous; a fill then sets every bitmap word (8 at defaults) to
//   ones while in_stall is high; free count and search word clear, config regs reload.
// ----------------------------------------------------------------------------
// slab_bitmap_slot_allocator: slot bitmap of one slab block
// Allocates slots round-robin, sets mark bits by word offset and clears all
// marks. Bitmap words live in a synchronous RAM; a sequencer reads, modifies
// and writes them back. Config registers sit here.
// ----------------------------------------------------------------------------
module slab_bitmap_slot_allocator #(
  parameter int MAX_SLOTS = 512,
  parameter int WORD_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sbsa_pkg::FUNC_W-1:0]     in_func,
  input  logic [sbsa_pkg::OFFS_W-1:0]     in_word_offset,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sbsa_pkg::STATUS_W-1:0]   out_status,
  output logic [sbsa_pkg::IDX_OUT_W-1:0]  out_slot_index,
  output logic [sbsa_pkg::SLOT_OFS_W-1:0] out_slot_offset,
  output logic                            out_scan_needed,
  output logic                            out_became_full,
  output logic [sbsa_pkg::CNT_W-1:0]      out_free_count,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbsa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sbsa_pkg::*;

  localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  // slot_count is 10 bits wide, so the clamp never exceeds its range
  localparam int MAX_CLAMP = (MAX_SLOTS > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : MAX_SLOTS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CLAMP);

  logic [CNT_W-1:0]  slot_count_r;
  logic [SIZE_W-1:0] slot_size_r;
  logic [HDR_W-1:0]  header_r;
  logic              has_ptr_r;
  cfg_t              cfg;
  result_t           res;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Config regs: always ready. The sequencer reads them live, so the user must
  // write them only between requests; the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= CNT_W'(500);
      slot_size_r  <= SIZE_W'(1);
      header_r     <= HDR_W'(10);
      has_ptr_r    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SLOT_COUNT:   slot_count_r <= cfg_data[CNT_W-1:0];
        REG_SLOT_SIZE:    slot_size_r  <= cfg_data[SIZE_W-1:0];
        REG_HEADER:       header_r     <= cfg_data[HDR_W-1:0];
        REG_HAS_POINTERS: has_ptr_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective values: zero count means one slot, too many is clamped;
  // zero size means one word.
  always_comb begin
    if (slot_count_r == '0) begin
      cfg.slot_count = CNT_W'(1);
    end else if (slot_count_r > MAX_CNT) begin
      cfg.slot_count = MAX_CNT;
    end else begin
      cfg.slot_count = slot_count_r;
    end
    cfg.slot_size    = (slot_size_r == '0) ? SIZE_W'(1) : slot_size_r;
    cfg.header       = header_r;
    cfg.has_pointers = has_ptr_r;
  end

  sbsa_ram #(
    .DEPTH (NUM_WORDS),
    .DW    (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sbsa_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_word_offset (in_word_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_res        (res),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  assign out_status      = res.status;
  assign out_slot_index  = res.slot_index;
  assign out_slot_offset = res.slot_offset;
  assign out_scan_needed = res.scan_needed;
  assign out_became_full = res.became_full;
  assign out_free_count  = res.free_count;

endmodule
